// ----- hw/rtl/gdad_pkg.sv -----
// Shared types, calendar constants and helper functions for the date adder.
`default_nettype none

package gdad_pkg;

  localparam logic [15:0] YEAR_MAX    = 16'hFFFF;
  localparam logic [3:0]  MONTH_JAN   = 4'd1;
  localparam logic [3:0]  MONTH_FEB   = 4'd2;
  localparam logic [3:0]  MONTH_APR   = 4'd4;
  localparam logic [3:0]  MONTH_JUN   = 4'd6;
  localparam logic [3:0]  MONTH_SEP   = 4'd9;
  localparam logic [3:0]  MONTH_NOV   = 4'd11;
  localparam logic [3:0]  MONTH_DEC   = 4'd12;
  localparam logic [4:0]  DAY_FIRST   = 5'd1;
  localparam logic [4:0]  LEN_LONG    = 5'd31;
  localparam logic [4:0]  LEN_SHORT   = 5'd30;
  localparam logic [4:0]  LEN_FEB_LEAP = 5'd29;
  localparam logic [4:0]  LEN_FEB     = 5'd28;

  // year mod 25 residue; with the low year bits it settles the century rules
  localparam logic [4:0]  RES25_LAST  = 5'd24;
  // floor(y / 25) = (y * DIV25_MULT) >> DIV25_SHIFT for every 16-bit y
  localparam int          DIV25_SHIFT = 21;
  localparam logic [32:0] DIV25_MULT  = 33'd83887;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] days;
    logic [4:0]  res25;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } back_state_t;

  // divisible by 4 and not by 100, or by 400 (400 = 16 * 25)
  function automatic logic is_leap(input logic [15:0] year, input logic [4:0] res25);
    logic div25;
    div25 = (res25 == 5'd0);
    return ((year[1:0] == 2'd0) && !div25) || ((year[3:0] == 4'd0) && div25);
  endfunction

  function automatic logic [4:0] month_length(input logic leap, input logic [3:0] month);
    logic [4:0] len;
    len = LEN_LONG;
    if (month == MONTH_APR || month == MONTH_JUN || month == MONTH_SEP ||
        month == MONTH_NOV) begin
      len = LEN_SHORT;
    end else if (month == MONTH_FEB) begin
      len = leap ? LEN_FEB_LEAP : LEN_FEB;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gregorian_date_add_days_core.sv -----
// Top level of the Gregorian date adder: front end, job queue, month stepper.
// The front end registers each item with its residue product and derives the residue and
//   clamp from it; the back end then steps one month per cycle across each month boundary
//   crossed (at most about 2160), starting a new job only once the last result is loaded.
// Reset: synchronous, active high; empties the queue and all valid flags, drops items.
`default_nettype none

module gregorian_date_add_days_core #(
  parameter int QUEUE_DEPTH = 2   // jobs buffered between front and back end
) (
  input  wire         clk,
  input  wire         rst,
  // input item side
  input  wire         push,
  output logic        full,
  input  wire  [15:0] start_year,
  input  wire  [3:0]  start_month,
  input  wire  [4:0]  start_day,
  input  wire  [15:0] days_to_add,
  // result item side
  output logic        empty,
  input  wire         pop,
  output logic [15:0] end_year,
  output logic [3:0]  end_month,
  output logic [4:0]  end_day,
  output logic        year_overflow
);

  // Front end: registers the item with the year * (2^21/25) product, then
  // derives year mod 25 and clamps month and day to a legal start date.
  logic           q_wr;
  logic           q_full;
  gdad_pkg::job_t q_wdata;

  // Back end side of the queue
  logic           q_rd;
  logic           q_empty;
  gdad_pkg::job_t q_rdata;

  gdad_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .start_year  (start_year),
    .start_month (start_month),
    .start_day   (start_day),
    .days_to_add (days_to_add),
    .q_wr        (q_wr),
    .q_full      (q_full),
    .q_data      (q_wdata)
  );

  // Decouples the classifier from the long-running stepper so a new item
  // can be taken while a date is still being walked forward.
  gdad_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Back end: each cycle either finishes inside the current month or jumps
  // to day 1 of the next one. Leap years come from the low year bits and a
  // mod-25 counter that tracks the year, so no division is needed per step.
  // The finished date sits in an output register until popped.
  gdad_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_rd          (q_rd),
    .q_data        (q_rdata),
    .empty         (empty),
    .pop           (pop),
    .end_year      (end_year),
    .end_month     (end_month),
    .end_day       (end_day),
    .year_overflow (year_overflow)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/gdad_front.sv -----
// Front end: accepts items, finds year mod 25 and clamps the start date.
`default_nettype none

module gdad_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  output logic             full,
  input  wire       [15:0] start_year,
  input  wire       [3:0]  start_month,
  input  wire       [4:0]  start_day,
  input  wire       [15:0] days_to_add,
  output logic             q_wr,
  input  wire              q_full,
  output gdad_pkg::job_t   q_data
);

  logic        hold_valid;
  logic [15:0] hold_year;
  logic [3:0]  hold_month;
  logic [4:0]  hold_day;
  logic [15:0] hold_days;
  logic [32:0] hold_prod;

  logic        accept;
  logic [32:0] prod;
  logic [11:0] quot;
  logic [15:0] quot25;
  logic [15:0] resid;
  logic [3:0]  month_c;
  logic [4:0]  day_c;
  logic [4:0]  len;

  assign full   = hold_valid && q_full;
  assign accept = push && !full;
  assign q_wr   = hold_valid && !q_full;
  assign prod   = {17'd0, start_year} * gdad_pkg::DIV25_MULT;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (q_wr) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_year  <= start_year;
      hold_month <= start_month;
      hold_day   <= start_day;
      hold_days  <= days_to_add;
      hold_prod  <= prod;
    end
  end

  // remainder by 25: quotient * 25 as shift-add
  always_comb begin
    quot   = hold_prod[gdad_pkg::DIV25_SHIFT +: 12];
    quot25 = ({4'd0, quot} << 4) + ({4'd0, quot} << 3) + {4'd0, quot};
    resid  = hold_year - quot25;

    if (hold_month == 4'd0) begin
      month_c = gdad_pkg::MONTH_JAN;
    end else if (hold_month > gdad_pkg::MONTH_DEC) begin
      month_c = gdad_pkg::MONTH_DEC;
    end else begin
      month_c = hold_month;
    end

    len   = gdad_pkg::month_length(gdad_pkg::is_leap(hold_year, resid[4:0]), month_c);
    day_c = (hold_day == 5'd0) ? gdad_pkg::DAY_FIRST : hold_day;
    if (day_c > len) begin
      day_c = len;
    end

    q_data.year  = hold_year;
    q_data.month = month_c;
    q_data.day   = day_c;
    q_data.days  = hold_days;
    q_data.res25 = resid[4:0];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/gdad_queue.sv -----
// Small first-in first-out queue of clamped jobs between front and back.
`default_nettype none

module gdad_queue #(
  parameter int DEPTH = 2
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             wr,
  input  gdad_pkg::job_t  wdata,
  output logic            full,
  input  wire             rd,
  output gdad_pkg::job_t  rdata,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  gdad_pkg::job_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CNT_FULL);
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CNT_FULL)
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
      do_wr && !do_rd |=> count == $past(count) + CNT_W'(1))
    else $error("queue count did not rise on write");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
      do_rd && !do_wr |=> count == $past(count) - CNT_W'(1))
    else $error("queue count did not fall on read");

endmodule

`default_nettype wire

// ----- hw/rtl/gdad_back.sv -----
// Back end: walks the date forward one month per cycle and holds the result.
`default_nettype none

module gdad_back (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   q_empty,
  output logic                  q_rd,
  input  gdad_pkg::job_t        q_data,
  output logic                  empty,
  input  wire                   pop,
  output logic [15:0]           end_year,
  output logic [3:0]            end_month,
  output logic [4:0]            end_day,
  output logic                  year_overflow
);

  gdad_pkg::back_state_t state, state_next;
  logic [15:0] y, y_next;
  logic [3:0]  m, m_next;
  logic [4:0]  d, d_next;
  logic [15:0] rem, rem_next;
  logic [4:0]  r25, r25_next;
  logic        ovf, ovf_next;

  logic        out_valid;
  logic        out_load;
  logic [4:0]  len;
  logic [4:0]  left;
  logic        fits;

  assign len  = gdad_pkg::month_length(gdad_pkg::is_leap(y, r25), m);
  assign left = len - d;
  assign fits = rem <= {11'd0, left};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gdad_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    y   <= y_next;
    m   <= m_next;
    d   <= d_next;
    rem <= rem_next;
    r25 <= r25_next;
    ovf <= ovf_next;
  end

  always_comb begin
    state_next = state;
    y_next     = y;
    m_next     = m;
    d_next     = d;
    rem_next   = rem;
    r25_next   = r25;
    ovf_next   = ovf;
    q_rd       = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      gdad_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_rd       = 1'b1;
          y_next     = q_data.year;
          m_next     = q_data.month;
          d_next     = q_data.day;
          rem_next   = q_data.days;
          r25_next   = q_data.res25;
          ovf_next   = 1'b0;
          state_next = gdad_pkg::ST_RUN;
        end
      end
      gdad_pkg::ST_RUN: begin
        if (fits) begin
          // rem is at most 30 here
          d_next     = d + rem[4:0];
          rem_next   = '0;
          state_next = gdad_pkg::ST_HOLD;
        end else begin
          rem_next = rem - {11'd0, left} - 16'd1;
          d_next   = gdad_pkg::DAY_FIRST;
          if (m == gdad_pkg::MONTH_DEC) begin
            m_next = gdad_pkg::MONTH_JAN;
            if (y == gdad_pkg::YEAR_MAX) begin
              y_next   = '0;
              r25_next = '0;
              ovf_next = 1'b1;
            end else begin
              y_next   = y + 16'd1;
              r25_next = (r25 == gdad_pkg::RES25_LAST) ? 5'd0 : r25 + 5'd1;
            end
          end else begin
            m_next = m + 4'd1;
          end
        end
      end
      gdad_pkg::ST_HOLD: begin
        if (!out_valid || pop) begin
          out_load   = 1'b1;
          state_next = gdad_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gdad_pkg::ST_IDLE;
      end
    endcase
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      end_year      <= y;
      end_month     <= m;
      end_day       <= d;
      year_overflow <= ovf;
    end
  end

  a_day_in_month: assert property (@(posedge clk) disable iff (rst)
      state == gdad_pkg::ST_RUN |-> d != 5'd0 && d <= len)
    else $error("day outside current month while stepping");
  a_res25_range: assert property (@(posedge clk) disable iff (rst)
      state == gdad_pkg::ST_RUN |-> r25 <= gdad_pkg::RES25_LAST)
    else $error("year residue out of range");
  a_result_kept: assert property (@(posedge clk) disable iff (rst)
      out_valid && !pop |=> out_valid && $stable(end_year) && $stable(end_day))
    else $error("waiting result lost or changed");

endmodule

`default_nettype wire

// ----- sim/gdad_checker.sv -----
// Checker for the date adder: watches the item and result sides, predicts each end date and compares it.
`timescale 1ns / 100ps

module gdad_checker (
  input  wire        clk,
  input  wire        rst,
  input  wire        push,
  input  wire        full,
  input  wire [15:0] start_year,
  input  wire [3:0]  start_month,
  input  wire [4:0]  start_day,
  input  wire [15:0] days_to_add,
  input  wire        empty,
  input  wire        pop,
  input  wire [15:0] end_year,
  input  wire [3:0]  end_month,
  input  wire [4:0]  end_day,
  input  wire        year_overflow,
  output int         errors,
  output int         awaiting
);

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        wrap;
  } end_date_t;

  // end dates owed by the block, oldest first
  end_date_t due_dates[$];

  function automatic int days_in_month(input int yr, input int mon);
    bit leap;
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    case (mon)
      gdad_pkg::MONTH_APR, gdad_pkg::MONTH_JUN, gdad_pkg::MONTH_SEP,
      gdad_pkg::MONTH_NOV: return int'(gdad_pkg::LEN_SHORT);
      gdad_pkg::MONTH_FEB:
        return leap ? int'(gdad_pkg::LEN_FEB_LEAP) : int'(gdad_pkg::LEN_FEB);
      default: return int'(gdad_pkg::LEN_LONG);
    endcase
  endfunction

  // steps a month at a time; each month is judged by its own length
  function automatic end_date_t advance_date(input logic [15:0] y0, input logic [3:0] m0,
                                             input logic [4:0] d0, input logic [15:0] n);
    end_date_t res;
    int yr, mon, dy, left, room;
    bit wrap;
    yr = y0;
    mon = m0;
    dy = d0;
    left = n;
    wrap = 1'b0;
    if (mon < gdad_pkg::MONTH_JAN) mon = gdad_pkg::MONTH_JAN;
    if (mon > gdad_pkg::MONTH_DEC) mon = gdad_pkg::MONTH_DEC;
    if (dy < gdad_pkg::DAY_FIRST) dy = gdad_pkg::DAY_FIRST;
    if (dy > days_in_month(yr, mon)) dy = days_in_month(yr, mon);
    while (left > 0) begin
      room = days_in_month(yr, mon) - dy;
      if (left <= room) begin
        dy += left;
        left = 0;
      end else begin
        left -= room + 1;
        dy = gdad_pkg::DAY_FIRST;
        if (mon == gdad_pkg::MONTH_DEC) begin
          mon = gdad_pkg::MONTH_JAN;
          if (yr == gdad_pkg::YEAR_MAX) begin
            yr = 0;
            wrap = 1'b1;
          end else begin
            yr++;
          end
        end else begin
          mon++;
        end
      end
    end
    res.year = yr[15:0];
    res.month = mon[3:0];
    res.day = dy[4:0];
    res.wrap = wrap;
    return res;
  endfunction

  function automatic int field_bad(input string name, input logic [15:0] want_v,
                                   input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    end_date_t want;
    int fails;
    fails = 0;
    if (rst) begin
      due_dates.delete();
      awaiting <= 0;
    end else begin
      if (push && !full) begin
        due_dates.push_back(advance_date(start_year, start_month, start_day, days_to_add));
      end
      if (pop && !empty) begin
        if (due_dates.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d-%0d-%0d overflow %0b",
                   $time, end_year, end_month, end_day, year_overflow);
          fails = 1;
        end else begin
          want = due_dates.pop_front();
          fails += field_bad("end_year", want.year, end_year);
          fails += field_bad("end_month", 16'(want.month), 16'(end_month));
          fails += field_bad("end_day", 16'(want.day), 16'(end_day));
          fails += field_bad("year_overflow", 16'(want.wrap), 16'(year_overflow));
        end
      end
      errors <= errors + fails;
      awaiting <= due_dates.size();
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the date adder: clock, reset, item and result traffic, verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES = 20;    // quiet time after the last result
  localparam int PHASE_ITEMS  = 50;    // random items per idling phase
  localparam int PACK_ITEMS   = 12;    // back-to-back items during the hold-off

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [15:0] start_year = '0;
  logic [3:0]  start_month = gdad_pkg::MONTH_JAN;
  logic [4:0]  start_day = gdad_pkg::DAY_FIRST;
  logic [15:0] days_to_add = '0;
  logic        pop = 1'b0;

  wire         full;
  wire         empty;
  wire  [15:0] end_year;
  wire  [3:0]  end_month;
  wire  [4:0]  end_day;
  wire         year_overflow;

  int errors;
  int awaiting;

  // idling knobs, percent of cycles
  int idle_pct = 0;
  int stall_pct = 0;

  // hold-off request: main bumps hold_seq, receiver notices the change
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always #6 clk = ~clk;

  gregorian_date_add_days_core uut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .start_year   (start_year),
    .start_month  (start_month),
    .start_day    (start_day),
    .days_to_add  (days_to_add),
    .empty        (empty),
    .pop          (pop),
    .end_year     (end_year),
    .end_month    (end_month),
    .end_day      (end_day),
    .year_overflow(year_overflow)
  );

  gdad_checker chk (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .start_year   (start_year),
    .start_month  (start_month),
    .start_day    (start_day),
    .days_to_add  (days_to_add),
    .empty        (empty),
    .pop          (pop),
    .end_year     (end_year),
    .end_month    (end_month),
    .end_day      (end_day),
    .year_overflow(year_overflow),
    .errors       (errors),
    .awaiting     (awaiting)
  );

  // Result side. One pop assignment per edge; a hold-off keeps pop low while
  // hold_left, loaded from HOLD_CYCLES, counts down here, while the sender keeps pushing.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one item. Called just after a rising edge; returns at the edge that
  // accepted it with push still high, so a following item goes out with no gap.
  task automatic send_item(input logic [15:0] yr, input logic [3:0] mon,
                           input logic [4:0] dy, input logic [15:0] n);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    start_year <= yr;
    start_month <= mon;
    start_day <= dy;
    days_to_add <= n;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Sender pause: stop pushing until every owed result has come back.
  // awaiting is registered in the checker, so look only after an edge.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  // Mostly valid dates with random content; a slice of out-of-range months
  // and days, years near the top so the year wrap shows up, and a tail of
  // large day counts. quick keeps the count small for the fill-up burst.
  task automatic random_item(input bit quick);
    logic [15:0] yr;
    logic [15:0] n;
    logic [3:0]  mon;
    logic [4:0]  dy;
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) yr = 16'($urandom_range(65535, 65400));
    else if (pick < 25) yr = 16'($urandom_range(50, 0));
    else yr = 16'($urandom_range(65535, 0));
    mon = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 0)) : 4'($urandom_range(12, 1));
    dy = ($urandom_range(4) == 0) ? 5'($urandom_range(31, 0)) : 5'($urandom_range(28, 1));
    pick = quick ? 0 : $urandom_range(99);
    if (pick < 55) n = 16'($urandom_range(60, 0));
    else if (pick < 80) n = 16'($urandom_range(1500, 0));
    else if (pick < 92) n = 16'($urandom_range(65535, 0));
    else n = 16'($urandom_range(65535, 65000));
    send_item(yr, mon, dy, n);
  endtask

  // Run limit, far above the slowest legal run.
  initial begin
    #36_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, no idling on either side.
    send_item(16'd2024, gdad_pkg::MONTH_FEB, 5'd28, 16'd1);    // leap February
    send_item(16'd2023, gdad_pkg::MONTH_FEB, 5'd28, 16'd1);    // common February
    send_item(16'd1900, gdad_pkg::MONTH_FEB, 5'd28, 16'd1);    // century, not leap
    send_item(16'd2000, gdad_pkg::MONTH_FEB, 5'd28, 16'd1);    // 400th year, leap
    send_item(16'd0, gdad_pkg::MONTH_FEB, 5'd29, 16'd0);       // year zero is leap, zero days
    send_item(16'd2021, 4'd0, 5'd15, 16'd10);                  // month zero clamps to January
    send_item(16'd2021, 4'd15, 5'd31, 16'd1);                  // month 15 clamps to December
    send_item(16'd2021, 4'd13, 5'd1, 16'd30);                  // month 13 clamps too
    send_item(16'd2021, 4'd5, 5'd0, 16'd0);                    // day zero becomes the 1st
    send_item(16'd2021, gdad_pkg::MONTH_APR, 5'd31, 16'd0);    // day past month end saturates
    send_item(16'd2023, gdad_pkg::MONTH_FEB, 5'd31, 16'd1);    // saturate then step
    send_item(gdad_pkg::YEAR_MAX, gdad_pkg::MONTH_DEC, 5'd31, 16'd1);   // year wraps to 0
    send_item(gdad_pkg::YEAR_MAX, gdad_pkg::MONTH_DEC, 5'd31, 16'd0);   // top date, nothing added
    send_item(gdad_pkg::YEAR_MAX, gdad_pkg::MONTH_JAN, 5'd1, 16'hFFFF); // wrap deep into year 0..
    send_item(16'd0, gdad_pkg::MONTH_JAN, 5'd1, 16'hFFFF);     // largest count from the start
    send_item(16'd2021, gdad_pkg::MONTH_JAN, 5'd31, 16'd1);    // month rollover
    send_item(16'd2023, gdad_pkg::MONTH_JAN, 5'd31, 16'd28);   // lands on Feb 28 by current length
    send_item(16'd2023, gdad_pkg::MONTH_JAN, 5'd31, 16'd29);   // one more crosses into March
    send_item(16'd2021, gdad_pkg::MONTH_DEC, 5'd31, 16'd365);  // full year ahead
    send_item(16'd2099, gdad_pkg::MONTH_DEC, 5'd31, 16'hFFFF); // century crossings
    send_item(16'hAAAA, 4'd10, 5'd31, 16'h5555);               // alternating bit patterns
    send_item(16'h5555, 4'd5, 5'd10, 16'hAAAA);
    drain();

    // Random part, one idling mix per phase; each phase ends with a drain.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 77;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 77;
        end
        3: begin
          idle_pct = 25;
          stall_pct = 25;
        end
        default: begin
          // receiver holds off while short items pour in until full stalls push
          idle_pct = 0;
          stall_pct = 0;
          hold_seq++;
          repeat (PACK_ITEMS) random_item(1'b1);
          idle_pct = 25;
          stall_pct = 25;
        end
      endcase
      repeat (PHASE_ITEMS) random_item(1'b0);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- gregorian_date_add_days_core.f -----
hw/rtl/gdad_pkg.sv
hw/rtl/gdad_front.sv
hw/rtl/gdad_queue.sv
hw/rtl/gdad_back.sv
hw/rtl/gregorian_date_add_days_core.sv
sim/gdad_checker.sv
sim/tb_top.sv
